// ----- rtl/itf_pkg.sv -----
package itf_pkg;
	localparam int SECTOR_WORDS = 256;
	localparam int SEEK_TICKS = 768;
	localparam int PTR_W = $clog2(SECTOR_WORDS) + 1;
	localparam int IDX_W = $clog2(SECTOR_WORDS);
	localparam int TMO_W = 10;

	localparam logic [2:0] REQ_READ = 3'd0;
	localparam logic [2:0] REQ_WRITE = 3'd1;
	localparam logic [2:0] REQ_TICK = 3'd2;
	localparam logic [2:0] REQ_RESET = 3'd3;
	localparam logic [2:0] REQ_FILL = 3'd4;

	localparam logic [2:0] PORT_DATA = 3'd0;
	localparam logic [2:0] PORT_ERROR = 3'd1;
	localparam logic [2:0] PORT_COUNT = 3'd2;
	localparam logic [2:0] PORT_SECTOR = 3'd3;
	localparam logic [2:0] PORT_CYL_LO = 3'd4;
	localparam logic [2:0] PORT_CYL_HI = 3'd5;
	localparam logic [2:0] PORT_HEAD = 3'd6;
	localparam logic [2:0] PORT_STATUS = 3'd7;

	localparam logic [7:0] ST_ERROR = 8'h01;
	localparam logic [7:0] ST_BUF_READY = 8'h08;
	localparam logic [7:0] ST_SEEK_DONE = 8'h10;
	localparam logic [7:0] ST_DRV_READY = 8'h40;
	localparam logic [7:0] ST_BUSY = 8'h80;
	localparam logic [7:0] CMD_READ = 8'h20;
	localparam logic [7:0] ERR_BAD_SECTOR = 8'h80;

	localparam logic [1:0] EVT_NONE = 2'd0;
	localparam logic [1:0] EVT_RESET = 2'd1;
	localparam logic [1:0] EVT_READ = 2'd2;

	localparam logic [0:0] CFG_SPT = 1'b0;
	localparam logic [0:0] CFG_HEADS = 1'b1;

	typedef enum logic [5:0] {
		OP_NOP = 6'b000001,
		OP_READ = 6'b000010,
		OP_WRITE = 6'b000100,
		OP_TICK = 6'b001000,
		OP_RESET = 6'b010000,
		OP_FILL = 6'b100000
	} op_t;

	typedef struct packed {
		op_t op;
		logic [2:0] port;
		logic [7:0] wbyte;
		logic [7:0] fill_index;
		logic [15:0] fill_word;
		logic fill_failed;
	} cmd_t;
endpackage

// ----- rtl/itf_front.sv -----
module itf_front import itf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] req_type,
	input logic [2:0] port,
	input logic [15:0] write_data,
	input logic [7:0] fill_index,
	input logic [15:0] fill_word,
	input logic fill_failed,
	output logic q_valid,
	output cmd_t q_cmd,
	input logic q_take
);
	// two-entry queue
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t c;
	logic push;

	always_comb begin
		c.port = port;
		c.wbyte = write_data[7:0];
		c.fill_index = fill_index;
		c.fill_word = fill_word;
		c.fill_failed = fill_failed;
		case (req_type)
			REQ_READ: c.op = OP_READ;
			REQ_WRITE: c.op = OP_WRITE;
			REQ_TICK: c.op = OP_TICK;
			REQ_RESET: c.op = OP_RESET;
			REQ_FILL: c.op = OP_FILL;
			default: c.op = OP_NOP;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule

// ----- rtl/itf_back.sv -----
module itf_back import itf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic q_valid,
	input cmd_t q_cmd,
	output logic q_take,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] read_data,
	output logic fetch_valid,
	output logic [27:0] fetch_sector
);
	logic [7:0] spt_q;
	logic [4:0] heads_q;
	logic [7:0] status_q, error_q, command_q;
	logic [TMO_W-1:0] tmo_q;
	logic [1:0] evt_q;
	logic [8:0] left_q;
	logic [7:0] sec_q;
	logic [15:0] cyl_q;
	logic [3:0] head_q;
	logic [7:0] headreg_q;
	logic [PTR_W-1:0] ptr_q;
	logic [15:0] buf_q [SECTOR_WORDS];
	logic [15:0] bufrd_q;

	// sequencer: S_IDLE -> S_RD -> S_IDLE (data-port read)
	//            S_IDLE -> S_MUL1 -> S_MUL2 -> S_IDLE (tick completing a read)
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_RD = 4'b0010, S_MUL1 = 4'b0100, S_MUL2 = 4'b1000
	} st_t;
	st_t st_q;
	logic [20:0] prod1_s1;
	logic [28:0] prod2_s2;

	logic busy_out;
	assign busy_out = out_valid && out_stall;
	assign q_take = q_valid && (st_q == S_IDLE) && !busy_out;

	always_ff @(posedge clk) begin
		if (q_take && q_cmd.op == OP_FILL && !q_cmd.fill_failed)
			buf_q[q_cmd.fill_index[IDX_W-1:0]] <= q_cmd.fill_word;
		bufrd_q <= buf_q[ptr_q[IDX_W-1:0]];
	end

	logic [8:0] s_nx;
	logic [4:0] h_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q <= 8'd17; heads_q <= 5'd4;
			status_q <= ST_BUSY; error_q <= '0; command_q <= '0;
			tmo_q <= '0; evt_q <= EVT_NONE; left_q <= '0;
			sec_q <= '0; cyl_q <= '0; head_q <= '0; headreg_q <= '0;
			ptr_q <= '0; st_q <= S_IDLE; out_valid <= 1'b0;
			read_data <= '0; fetch_valid <= 1'b0; fetch_sector <= '0;
			prod1_s1 <= '0; prod2_s2 <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_SPT) spt_q <= cfg_data;
				else heads_q <= cfg_data[4:0];
			end
			case (st_q)
				S_IDLE: if (q_take) begin
					read_data <= '0; fetch_valid <= 1'b0; fetch_sector <= '0;
					out_valid <= 1'b1;
					case (q_cmd.op)
						OP_READ: case (q_cmd.port)
							PORT_DATA: if (status_q[3]) begin
								if (ptr_q < PTR_W'(SECTOR_WORDS)) begin
									out_valid <= 1'b0;
									st_q <= S_RD;
								end else read_data <= 16'hFFFF;
							end
							PORT_ERROR: read_data <= {8'h00, error_q};
							PORT_SECTOR: read_data <= {8'h00, sec_q};
							PORT_CYL_LO: read_data <= {8'h00, cyl_q[7:0]};
							PORT_CYL_HI: read_data <= {8'h00, cyl_q[15:8]};
							PORT_HEAD: read_data <= {8'h00, headreg_q};
							PORT_STATUS: read_data <= {8'h00, status_q};
							default: ;
						endcase
						OP_WRITE: case (q_cmd.port)
							PORT_COUNT: left_q <= (q_cmd.wbyte == 8'd0) ? 9'd256
								: {1'b0, q_cmd.wbyte};
							PORT_SECTOR: sec_q <= q_cmd.wbyte;
							PORT_CYL_LO: cyl_q[7:0] <= q_cmd.wbyte;
							PORT_CYL_HI: cyl_q[15:8] <= q_cmd.wbyte;
							PORT_HEAD: begin
								head_q <= q_cmd.wbyte[3:0];
								headreg_q <= q_cmd.wbyte;
							end
							PORT_STATUS: begin
								command_q <= q_cmd.wbyte;
								if (q_cmd.wbyte == CMD_READ) begin
									status_q <= (status_q & ~ST_DRV_READY) | ST_BUSY;
									tmo_q <= TMO_W'(SEEK_TICKS);
									evt_q <= EVT_READ;
								end
							end
							default: ;
						endcase
						OP_TICK: if (tmo_q != '0) begin
							tmo_q <= tmo_q - 1'b1;
							if (tmo_q == TMO_W'(1)) begin
								evt_q <= EVT_NONE;
								if (evt_q == EVT_RESET)
									status_q <= (status_q & ~ST_BUSY) | ST_DRV_READY
										| ST_SEEK_DONE;
								else if (evt_q == EVT_READ) begin
									out_valid <= 1'b0;
									prod1_s1 <= cyl_q * heads_q;
									st_q <= S_MUL1;
								end
							end
						end
						OP_RESET: begin
							status_q <= ST_BUSY; error_q <= '0; command_q <= '0;
							tmo_q <= TMO_W'(2); evt_q <= EVT_RESET;
						end
						OP_FILL: if (q_cmd.fill_failed) begin
							status_q <= status_q | ST_ERROR;
							error_q <= ERR_BAD_SECTOR;
						end
						default: ;
					endcase
				end
				S_RD: begin
					read_data <= ~bufrd_q;
					ptr_q <= ptr_q + 1'b1;
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				S_MUL1: begin
					prod2_s2 <= 29'((prod1_s1 + {17'd0, head_q}) * spt_q);
					st_q <= S_MUL2;
				end
				S_MUL2: begin
					fetch_sector <= 28'(prod2_s2 + {21'd0, sec_q} + 29'h0FFFFFFF);
					fetch_valid <= 1'b1;
					out_valid <= 1'b1;
					status_q <= (status_q & ~(ST_BUSY | ST_ERROR)) | ST_BUF_READY
						| ST_SEEK_DONE;
					error_q <= '0;
					ptr_q <= '0;
					if (left_q != 9'd1) begin
						if (s_nx > {1'b0, spt_q}) begin
							sec_q <= 8'd1;
							if (h_nx >= heads_q || h_nx > 5'd15) begin
								head_q <= '0;
								cyl_q <= cyl_q + 1'b1;
							end else head_q <= h_nx[3:0];
						end else sec_q <= s_nx[7:0];
					end
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
	assign s_nx = {1'b0, sec_q} + 9'd1;
	assign h_nx = {1'b0, head_q} + 5'd1;
endmodule

// ----- rtl/ide_task_file_read_controller.sv -----
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | req_type port write_data fill_index fill_word fill_failed
// out      | out_valid / out_stall| read_data fetch_valid fetch_sector
// cfg      | cfg_we               | cfg_index cfg_data
// One result beat per input beat. Most items finish in S_IDLE; a data-port
// read passes S_RD (registered buffer read), a seek completion S_MUL1 and
// S_MUL2 (two registered multiplies for the CHS-to-linear index).
// A two-beat queue decouples input from the back end.
// arst_n resets all control state; buffer contents are undefined until filled.
// out_stall holds the result register; the back end stops taking from the queue.
module ide_task_file_read_controller import itf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] req_type,
	input logic [2:0] port,
	input logic [15:0] write_data,
	input logic [7:0] fill_index,
	input logic [15:0] fill_word,
	input logic fill_failed,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] read_data,
	output logic fetch_valid,
	output logic [27:0] fetch_sector
);
	logic q_valid, q_take;
	cmd_t q_cmd;

	itf_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .port, .write_data,
		.fill_index, .fill_word, .fill_failed, .q_valid, .q_cmd, .q_take
	);

	itf_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_cmd, .q_take,
		.out_valid, .out_stall, .read_data, .fetch_valid, .fetch_sector
	);
endmodule

// ----- rtl/itf_checker.sv -----
module itf_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [15:0] read_data,
	input logic fetch_valid,
	input logic [27:0] fetch_sector
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data)
			&& $stable(fetch_sector))
		else $error("stalled result changed");
	a_fetch_rd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fetch_valid |-> read_data == 16'h0000)
		else $error("fetch with read data");
	a_nofetch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fetch_valid |-> fetch_sector == 28'h0)
		else $error("sector without fetch");
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("valid in reset");
endmodule

bind ide_task_file_read_controller itf_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall,
	.read_data, .fetch_valid, .fetch_sector
);
